[design/gnp_pkg.sv]
// ----------------------------------------------------------------------------
// gnp_pkg: shared definitions for the grid nearest-point window search
// Widths, command and register codes, pipeline structs and bit-search helpers.
// ----------------------------------------------------------------------------
package gnp_pkg;

    // Grid geometry
    localparam int COORD_W   = 6;
    localparam int GRID_SIZE = 1 << COORD_W;
    localparam int SCOORD_W  = COORD_W + 2;     // signed window bounds
    localparam int DIST_W    = 2 * COORD_W + 1; // squared distance
    localparam int HEAD_W    = 10;
    localparam int CMD_W     = 2;
    localparam int COUNT_W   = 13;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_DIST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_DIST  = 1'b1;
    localparam logic [CFG_W-1:0]     SIDE_RESET    = 6'd5;
    localparam logic [CFG_W-1:0]     FWD_RESET     = 6'd10;

    // Heading quadrants
    localparam logic [HEAD_W-1:0] HEAD_ROUND = 10'd128;
    localparam logic [1:0] QUAD_XPOS = 2'd0;
    localparam logic [1:0] QUAD_YPOS = 2'd1;
    localparam logic [1:0] QUAD_XNEG = 2'd2;
    localparam logic [1:0] QUAD_YNEG = 2'd3;

    typedef logic [COORD_W-1:0]          coord_t;
    typedef logic signed [SCOORD_W-1:0]  scoord_t;
    typedef logic [GRID_SIZE-1:0]        row_t;

    // Column issued to the memory, aligned with its read data
    typedef struct packed {
        logic   vld;
        coord_t x;
        coord_t dx;
    } col_meta_t;

    // Nearest marked cell of one column
    typedef struct packed {
        logic   vld;
        logic   hit;
        coord_t x;
        coord_t y;
        coord_t dx;
        coord_t dy;
    } cand_t;

    typedef struct packed {
        logic   hit;
        coord_t idx;
    } bit_pos_t;

    // Index of the lowest set bit: isolate it, then encode the one-hot word
    function automatic bit_pos_t lowest_set(row_t w);
        row_t     iso;
        bit_pos_t r;
        iso   = w & (~w + 1'b1);
        r.hit = |w;
        r.idx = '0;
        for (int i = 0; i < GRID_SIZE; i++) begin
            if (iso[i]) begin
                r.idx = r.idx | COORD_W'(i);
            end
        end
        return r;
    endfunction

    // Index of the highest set bit, through the reversed word
    function automatic bit_pos_t highest_set(row_t w);
        row_t     rv;
        bit_pos_t r;
        for (int i = 0; i < GRID_SIZE; i++) begin
            rv[i] = w[GRID_SIZE-1-i];
        end
        r     = lowest_set(rv);
        r.idx = COORD_W'(GRID_SIZE - 1) - r.idx;
        return r;
    endfunction

endpackage

[design/gnp_occ_mem.sv]
// ----------------------------------------------------------------------------
// gnp_occ_mem: occupancy bitmap store
// One row word per x column, bit y marks cell (x, y). Registered read, one
// write port, and a valid bit per row so that unwritten rows read as empty.
// ----------------------------------------------------------------------------
module gnp_occ_mem (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            rd_en,
    input  gnp_pkg::coord_t rd_addr,
    output gnp_pkg::row_t   rd_data,
    input  logic            wr_en,
    input  gnp_pkg::coord_t wr_addr,
    input  gnp_pkg::row_t   wr_data
);
    import gnp_pkg::*;

    row_t                 occ_mem [GRID_SIZE];
    row_t                 rd_q_reg;
    logic                 rd_ok_reg;
    logic [GRID_SIZE-1:0] row_vld_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            occ_mem[wr_addr] <= wr_data;
        end
    end

    // Read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q_reg <= occ_mem[rd_addr];
        end
    end

    // Track written rows; reset empties the grid at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end else begin
            if (wr_en) begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_ok_reg <= row_vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_ok_reg ? rd_q_reg : '0;

endmodule

[design/gnp_col_eval.sv]
// ----------------------------------------------------------------------------
// gnp_col_eval: column evaluation stage
// Masks one row word to the window's y span and picks the marked cell nearest
// the searcher row, lower y first on a tie. Result is registered.
// ----------------------------------------------------------------------------
module gnp_col_eval (
    input  logic               aclk,
    input  logic               aresetn,
    input  gnp_pkg::col_meta_t meta_in,
    input  gnp_pkg::row_t      row_in,
    input  gnp_pkg::coord_t    py,
    input  gnp_pkg::scoord_t   ylo,
    input  gnp_pkg::scoord_t   yhi,
    output gnp_pkg::cand_t     cand_out
);
    import gnp_pkg::*;

    row_t     dn_mask;
    row_t     up_mask;
    bit_pos_t dn_pos;
    bit_pos_t up_pos;
    coord_t   dy_dn;
    coord_t   dy_up;
    cand_t    cand_next;
    cand_t    cand_reg;

    // Split the window span at the searcher row
    always_comb begin
        for (int i = 0; i < GRID_SIZE; i++) begin
            dn_mask[i] = (SCOORD_W'(i) >= ylo) && (COORD_W'(i) <= py);
            up_mask[i] = (COORD_W'(i) > py) && (SCOORD_W'(i) <= yhi);
        end
    end

    assign dn_pos = highest_set(row_in & dn_mask);
    assign up_pos = lowest_set(row_in & up_mask);
    assign dy_dn  = py - dn_pos.idx;
    assign dy_up  = up_pos.idx - py;

    // Pick the nearer side; the lower row wins a tie
    always_comb begin
        cand_next.vld = meta_in.vld;
        cand_next.hit = dn_pos.hit || up_pos.hit;
        cand_next.x   = meta_in.x;
        cand_next.dx  = meta_in.dx;
        if (dn_pos.hit && (!up_pos.hit || (dy_dn <= dy_up))) begin
            cand_next.y  = dn_pos.idx;
            cand_next.dy = dy_dn;
        end else begin
            cand_next.y  = up_pos.idx;
            cand_next.dy = dy_up;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg.vld <= 1'b0;
        end else begin
            cand_reg <= cand_next;
        end
    end

    assign cand_out = cand_reg;

endmodule

[design/grid_nearest_point_window_search.sv]
// ----------------------------------------------------------------------------
// grid_nearest_point_window_search: occupancy grid with nearest-point search
// Keeps a 64 x 64 bitmap of marked cells and their count; returns the nearest
// marked cell inside a heading-dependent window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one request per command (add, remove, search) with the
//   point or searcher position and heading. Output channel m_*: exactly one
//   result per request, in order. Config writes (cfg_*) set the window side
//   and forward distance; the user makes them only while no request is in
//   flight, and the block itself does not enforce that.
// Sequencing:
//   One request at a time. Add and remove read the column word, write it
//   back and load the output register. Search reads each window column
//   inside the grid (up to 2*side+1 or forward+1, at most 64): the bitmap
//   memory delivers one column word per cycle, followed by a two-stage
//   column evaluation and distance compare.
// Reset:
//   Synchronous, active low. Empties the grid, zeroes the count, restores side
//   5 and forward 10, and drops any pending result.
// Stall:
//   A finished result waits in the output register; the next request is
//   accepted and processed meanwhile and is held back only if it finishes
//   before the receiver takes the waiting result.
// ----------------------------------------------------------------------------
module grid_nearest_point_window_search (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [gnp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gnp_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [gnp_pkg::CMD_W-1:0]        s_cmd,
    input  logic [gnp_pkg::COORD_W-1:0]      s_x_coord,
    input  logic [gnp_pkg::COORD_W-1:0]      s_y_coord,
    input  logic [gnp_pkg::HEAD_W-1:0]       s_heading,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_found,
    output logic [gnp_pkg::COORD_W-1:0]      m_found_x,
    output logic [gnp_pkg::COORD_W-1:0]      m_found_y,
    output logic [gnp_pkg::COUNT_W-1:0]      m_point_count
);
    import gnp_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_WR    = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    coord_t             px_reg, px_next;
    coord_t             py_reg, py_next;
    logic [CFG_W-1:0]   side_reg;
    logic [CFG_W-1:0]   fwd_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    coord_t             xcur_reg, xcur_next;
    coord_t             xend_reg, xend_next;
    scoord_t            ylo_reg, ylo_next;
    scoord_t            yhi_reg, yhi_next;
    col_meta_t          meta_reg, meta_next;
    logic               best_found_reg, best_found_next;
    coord_t             best_x_reg, best_x_next;
    coord_t             best_y_reg, best_y_next;
    logic [DIST_W-1:0]  best_d_reg, best_d_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_found_reg, m_found_next;
    coord_t             m_found_x_reg, m_found_x_next;
    coord_t             m_found_y_reg, m_found_y_next;
    logic [COUNT_W-1:0] m_point_count_reg, m_point_count_next;

    logic              s_fire;
    logic [HEAD_W-1:0] head_sum;
    logic [1:0]        quad;
    scoord_t           spx, spy, sside, sfwd;
    scoord_t           xl, xr, dn_span, up_span;
    coord_t            x_start, x_stop;

    logic              rd_en;
    coord_t            rd_addr;
    row_t              rd_data;
    logic              wr_en;
    row_t              wr_data;
    row_t              cell_bit;
    cand_t             cand;
    logic [2*COORD_W-1:0] dx_sq, dy_sq;
    logic [DIST_W-1:0] cand_dist;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    // Window setup from the incoming request
    assign head_sum = s_heading + HEAD_ROUND;
    assign quad     = head_sum[HEAD_W-1:HEAD_W-2];
    assign spx      = scoord_t'({2'b00, s_x_coord});
    assign spy      = scoord_t'({2'b00, s_y_coord});
    assign sside    = scoord_t'({2'b00, side_reg});
    assign sfwd     = scoord_t'({2'b00, fwd_reg});

    always_comb begin
        case (quad)
            QUAD_XPOS: begin
                xl = spx;         xr = spx + sfwd;
                dn_span = sside;  up_span = sside;
            end
            QUAD_YPOS: begin
                xl = spx - sside; xr = spx + sside;
                dn_span = '0;     up_span = sfwd;
            end
            QUAD_XNEG: begin
                xl = spx - sfwd;  xr = spx;
                dn_span = sside;  up_span = sside;
            end
            default: begin
                xl = spx - sside; xr = spx + sside;
                dn_span = sfwd;   up_span = '0;
            end
        endcase
    end

    // Clip the column range to the grid
    assign x_start = (xl < 0) ? '0 : xl[COORD_W-1:0];
    assign x_stop  = (xr > scoord_t'(GRID_SIZE - 1)) ? coord_t'(GRID_SIZE - 1)
                                                      : xr[COORD_W-1:0];

    // Squared distance of the column candidate
    assign dx_sq     = {{COORD_W{1'b0}}, cand.dx} * {{COORD_W{1'b0}}, cand.dx};
    assign dy_sq     = {{COORD_W{1'b0}}, cand.dy} * {{COORD_W{1'b0}}, cand.dy};
    assign cand_dist = {1'b0, dx_sq} + {1'b0, dy_sq};

    assign cell_bit = row_t'(1) << py_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= SIDE_RESET;
            fwd_reg  <= FWD_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SIDE_DIST: side_reg <= cfg_wdata;
                REG_FWD_DIST:  fwd_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer, read-modify-write and search sweep
    always_comb begin
        state_next         = state_reg;
        cmd_next           = cmd_reg;
        px_next            = px_reg;
        py_next            = py_reg;
        count_next         = count_reg;
        xcur_next          = xcur_reg;
        xend_next          = xend_reg;
        ylo_next           = ylo_reg;
        yhi_next           = yhi_reg;
        meta_next.vld      = 1'b0;
        meta_next.x        = xcur_reg;
        meta_next.dx       = (px_reg > xcur_reg) ? (px_reg - xcur_reg)
                                                 : (xcur_reg - px_reg);
        best_found_next    = best_found_reg;
        best_x_next        = best_x_reg;
        best_y_next        = best_y_reg;
        best_d_next        = best_d_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_found_next       = m_found_reg;
        m_found_x_next     = m_found_x_reg;
        m_found_y_next     = m_found_y_reg;
        m_point_count_next = m_point_count_reg;
        rd_en              = 1'b0;
        rd_addr            = px_reg;
        wr_en              = 1'b0;
        wr_data            = rd_data;

        // Keep the first strictly nearer candidate in scan order
        if (cand.vld && cand.hit && (!best_found_reg || (cand_dist < best_d_reg))) begin
            best_found_next = 1'b1;
            best_x_next     = cand.x;
            best_y_next     = cand.y;
            best_d_next     = cand_dist;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    cmd_next        = s_cmd;
                    px_next         = s_x_coord;
                    py_next         = s_y_coord;
                    xcur_next       = x_start;
                    xend_next       = x_stop;
                    ylo_next        = spy - dn_span;
                    yhi_next        = spy + up_span;
                    best_found_next = 1'b0;
                    best_x_next     = '0;
                    best_y_next     = '0;
                    best_d_next     = '0;
                    if (s_cmd inside {CMD_ADD, CMD_REMOVE}) begin
                        state_next = ST_RD;
                    end else if (s_cmd == CMD_SEARCH) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RD: begin
                rd_en      = 1'b1;
                state_next = ST_WR;
            end
            ST_WR: begin
                // Write back only when the cell changes
                if ((cmd_reg == CMD_ADD) && ((rd_data & cell_bit) == '0)) begin
                    wr_en      = 1'b1;
                    wr_data    = rd_data | cell_bit;
                    count_next = count_reg + 1'b1;
                end else if ((cmd_reg == CMD_REMOVE) && ((rd_data & cell_bit) != '0)) begin
                    wr_en      = 1'b1;
                    wr_data    = rd_data & ~cell_bit;
                    count_next = count_reg - 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                rd_en         = 1'b1;
                rd_addr       = xcur_reg;
                meta_next.vld = 1'b1;
                if (xcur_reg == xend_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    xcur_next = xcur_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!meta_reg.vld && !cand.vld) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_found_next       = (cmd_reg == CMD_SEARCH) && best_found_reg;
                    m_found_x_next     = (cmd_reg == CMD_SEARCH) ? best_x_reg : '0;
                    m_found_y_next     = (cmd_reg == CMD_SEARCH) ? best_y_reg : '0;
                    m_point_count_next = count_reg;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            meta_reg.vld   <= 1'b0;
            best_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            meta_reg       <= meta_next;
            best_found_reg <= best_found_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg           <= cmd_next;
        px_reg            <= px_next;
        py_reg            <= py_next;
        xcur_reg          <= xcur_next;
        xend_reg          <= xend_next;
        ylo_reg           <= ylo_next;
        yhi_reg           <= yhi_next;
        best_x_reg        <= best_x_next;
        best_y_reg        <= best_y_next;
        best_d_reg        <= best_d_next;
        m_found_reg       <= m_found_next;
        m_found_x_reg     <= m_found_x_next;
        m_found_y_reg     <= m_found_y_next;
        m_point_count_reg <= m_point_count_next;
    end

    gnp_occ_mem u_occ_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (px_reg),
        .wr_data (wr_data)
    );

    gnp_col_eval u_col_eval (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .meta_in  (meta_reg),
        .row_in   (rd_data),
        .py       (py_reg),
        .ylo      (ylo_reg),
        .yhi      (yhi_reg),
        .cand_out (cand)
    );

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_found_x     = m_found_x_reg;
    assign m_found_y     = m_found_y_reg;
    assign m_point_count = m_point_count_reg;

endmodule

[design/gnp_checker.sv]
// ----------------------------------------------------------------------------
// gnp_checker: port-level checks for the grid nearest-point window search
// Watches the request and result channels and flags illegal behavior.
// ----------------------------------------------------------------------------
module gnp_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic                             m_found,
    input logic [gnp_pkg::COORD_W-1:0]      m_found_x,
    input logic [gnp_pkg::COORD_W-1:0]      m_found_y,
    input logic [gnp_pkg::COUNT_W-1:0]      m_point_count
);
    import gnp_pkg::*;

    // Drop any pending result at reset
    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result still valid after reset");

    // Hold a stalled result
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_found_x)
            && $stable(m_found_y) && $stable(m_point_count))
        else $error("stalled result changed");

    // One request at a time: ready drops after a request is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in flight");

    // A found point means the grid holds at least one point
    a_found_needs_points: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_point_count != '0)
        else $error("point found in an empty grid");

    // No point reported means zero coordinates
    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_found_x == '0 && m_found_y == '0)
        else $error("coordinates reported without a found point");

endmodule

bind grid_nearest_point_window_search gnp_checker u_gnp_checker (.*);

[verif/grid_nearest_point_window_search_test.sv]
// ----------------------------------------------------------------------------
// grid_nearest_point_window_search_test: self-checking bench for the grid search
// Drives add, remove and search requests under several window settings and
// idle patterns. Most results are checked against a cycle-free occupancy model.
// ----------------------------------------------------------------------------
module grid_nearest_point_window_search_test;
    import gnp_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int PHASE_ITEMS   = 125;
    localparam int RANDOM_PHASES = 8;
    localparam int DIRECTED_ROWS = 25;
    localparam int RECENT_DEPTH  = 16;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        coord_t            x;
        coord_t            y;
        logic [HEAD_W-1:0] heading;
    } grid_request_t;

    typedef struct packed {
        logic               found;
        coord_t             fx;
        coord_t             fy;
        logic [COUNT_W-1:0] count;
    } grid_result_t;

    // One directed request; the result is typed in only where it is obvious
    typedef struct {
        logic [CMD_W-1:0] cmd;
        int               x;
        int               y;
        int               heading;
        bit               typed;
        bit               found;
        int               fx;
        int               fy;
        int               count;
    } directed_row_t;

    typedef struct {
        bit rand_window;
        int side;
        int fwd;
        int send_idle;
        int recv_stall;
        bit pause_mid;
    } phase_plan_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_cmd;
    coord_t               s_x_coord;
    coord_t               s_y_coord;
    logic [HEAD_W-1:0]    s_heading;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_found;
    coord_t               m_found_x;
    coord_t               m_found_y;
    logic [COUNT_W-1:0]   m_point_count;

    // Model state: occupied[x][y], marked count and window registers
    logic [GRID_SIZE-1:0] occupied [GRID_SIZE];
    logic [COUNT_W-1:0]   marked;
    logic [CFG_W-1:0]     side_dist;
    logic [CFG_W-1:0]     fwd_dist;

    grid_result_t awaited_results [$];
    int           mismatch_count = 0;
    int           quiet_cycles   = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           hot_x;
    int           hot_y;
    coord_t       recent_x [RECENT_DEPTH];
    coord_t       recent_y [RECENT_DEPTH];
    int           recent_fill = 0;
    int           recent_next = 0;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // empty grid, then the plain count cases
        '{CMD_SEARCH,  0,  0,    0, 1'b1, 1'b0, 0, 0, 0},
        '{CMD_ADD,     0,  0,    0, 1'b1, 1'b0, 0, 0, 1},
        '{CMD_ADD,    63, 63,    0, 1'b1, 1'b0, 0, 0, 2},
        '{CMD_ADD,     0,  0,    0, 1'b1, 1'b0, 0, 0, 2},
        '{CMD_REMOVE,  5,  5,    0, 1'b1, 1'b0, 0, 0, 2},
        '{CMD_UNUSED, 63, 63, 1023, 1'b1, 1'b0, 0, 0, 2},
        // windows hanging over every grid edge, each quadrant
        '{CMD_SEARCH,  0,  0,  127, 1'b0, 1'b0, 0, 0, 0},
        '{CMD_SEARCH, 63, 63, 1023, 1'b0, 1'b0, 0, 0, 0},
        '{CMD_SEARCH,  0,  0,  384, 1'b0, 1'b0, 0, 0, 0},
        '{CMD_SEARCH, 63, 63,  640, 1'b0, 1'b0, 0, 0, 0},
        '{CMD_SEARCH, 63,  0,  128, 1'b0, 1'b0, 0, 0, 0},
        // two cells at equal distance, first in scan order wins
        '{CMD_ADD,     9, 13,    0, 1'b0, 1'b0, 0, 0, 0},
        '{CMD_ADD,    11, 13,    0, 1'b0, 1'b0, 0, 0, 0},
        '{CMD_ADD,    10, 17,    0, 1'b0, 1'b0, 0, 0, 0},
        '{CMD_SEARCH, 10, 12,  256, 1'b0, 1'b0, 0, 0, 0},
        '{CMD_SEARCH, 10, 12,  896, 1'b0, 1'b0, 0, 0, 0},
        '{CMD_SEARCH, 20, 13,  512, 1'b0, 1'b0, 0, 0, 0},
        '{CMD_REMOVE,  9, 13,    0, 1'b0, 1'b0, 0, 0, 0},
        '{CMD_SEARCH, 10, 12,  255, 1'b0, 1'b0, 0, 0, 0},
        '{CMD_REMOVE,  0,  0,    0, 1'b0, 1'b0, 0, 0, 0},
        '{CMD_REMOVE, 63, 63,    0, 1'b0, 1'b0, 0, 0, 0},
        '{CMD_ADD,    63,  0,    0, 1'b0, 1'b0, 0, 0, 0},
        '{CMD_ADD,     0, 63,    0, 1'b0, 1'b0, 0, 0, 0},
        '{CMD_SEARCH,  0, 63,  767, 1'b0, 1'b0, 0, 0, 0},
        '{CMD_SEARCH, 63,  0,  895, 1'b0, 1'b0, 0, 0, 0}
    };

    phase_plan_t phase_plans [RANDOM_PHASES] = '{
        '{1'b0,  0,  0,  0,  0, 1'b0},
        '{1'b0, 63, 63, 75,  0, 1'b1},
        '{1'b0,  3,  7,  0, 75, 1'b0},
        '{1'b1,  0,  0, 20, 20, 1'b1},
        '{1'b0, 63,  0,  0,  0, 1'b0},
        '{1'b0,  0, 63, 75,  0, 1'b0},
        '{1'b1,  0,  0,  0, 75, 1'b0},
        '{1'b0,  5, 10, 20, 20, 1'b0}
    };

    grid_nearest_point_window_search DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_x_coord     (s_x_coord),
        .s_y_coord     (s_y_coord),
        .s_heading     (s_heading),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_found_x     (m_found_x),
        .m_found_y     (m_found_y),
        .m_point_count (m_point_count)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Apply one request to the model and return the result it produces
    function automatic grid_result_t apply_command(grid_request_t r);
        grid_result_t    res;
        int              px, py, s, f, d, best;
        int              xl, xr, yb, yt;
        logic [HEAD_W:0] hsum;
        res  = '0;
        px   = r.x;
        py   = r.y;
        s    = side_dist;
        f    = fwd_dist;
        best = 0;
        case (r.cmd)
            CMD_ADD: begin
                if (!occupied[r.x][r.y]) begin
                    occupied[r.x][r.y] = 1'b1;
                    marked = marked + 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (occupied[r.x][r.y]) begin
                    occupied[r.x][r.y] = 1'b0;
                    marked = marked - 1'b1;
                end
            end
            CMD_SEARCH: begin
                hsum = {1'b0, r.heading} + HEAD_ROUND;
                case (hsum[9:8])
                    QUAD_XPOS: begin
                        xl = px;     xr = px + f; yb = py - s; yt = py + s;
                    end
                    QUAD_YPOS: begin
                        xl = px - s; xr = px + s; yb = py;     yt = py + f;
                    end
                    QUAD_XNEG: begin
                        xl = px - f; xr = px;     yb = py - s; yt = py + s;
                    end
                    default: begin
                        xl = px - s; xr = px + s; yb = py - f; yt = py;
                    end
                endcase
                // Scan x ascending, then y; keep the first strictly nearer cell
                for (int x = xl; x <= xr; x++) begin
                    if (x >= 0 && x < GRID_SIZE) begin
                        for (int y = yb; y <= yt; y++) begin
                            if (y >= 0 && y < GRID_SIZE && occupied[x][y]) begin
                                d = (px - x) * (px - x) + (py - y) * (py - y);
                                if (!res.found || d < best) begin
                                    res.found = 1'b1;
                                    best      = d;
                                    res.fx    = coord_t'(x);
                                    res.fy    = coord_t'(y);
                                end
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.count = marked;
        return res;
    endfunction

    // Pick a random request, mostly near the phase's hot spot so searches hit
    function automatic grid_request_t draw_request();
        grid_request_t r;
        int            pick;
        int            k;
        pick      = $urandom_range(99);
        r.heading = HEAD_W'($urandom_range(1023));
        if ($urandom_range(99) < 60) begin
            r.x = coord_t'(hot_x + $urandom_range(16) - 8);
            r.y = coord_t'(hot_y + $urandom_range(16) - 8);
        end else begin
            r.x = coord_t'($urandom_range(63));
            r.y = coord_t'($urandom_range(63));
        end
        if (pick < 45) begin
            r.cmd = CMD_ADD;
            recent_x[recent_next] = r.x;
            recent_y[recent_next] = r.y;
            recent_next = (recent_next + 1) % RECENT_DEPTH;
            if (recent_fill < RECENT_DEPTH) recent_fill++;
        end else if (pick < 60) begin
            r.cmd = CMD_REMOVE;
            // Aim most removes at cells that were recently marked
            if (recent_fill > 0 && $urandom_range(99) < 70) begin
                k   = $urandom_range(recent_fill - 1);
                r.x = recent_x[k];
                r.y = recent_y[k];
            end
        end else if (pick < 95) begin
            r.cmd = CMD_SEARCH;
        end else begin
            r.cmd = CMD_UNUSED;
        end
        return r;
    endfunction

    // Hold the request on the input port until it is taken
    task automatic send_request(input grid_request_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= r.cmd;
        s_x_coord <= r.x;
        s_y_coord <= r.y;
        s_heading <= r.heading;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid and hold until every awaited result has come back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_window(input int side, input int fwd);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SIDE_DIST;
        cfg_wdata <= CFG_W'(side);
        @(posedge aclk);
        cfg_index <= REG_FWD_DIST;
        cfg_wdata <= CFG_W'(fwd);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        side_dist = CFG_W'(side);
        fwd_dist  = CFG_W'(fwd);
    endtask

    // Receiver: stall at the rate of the current phase
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each taken result with the oldest awaited one
    always @(posedge aclk) begin
        grid_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result with no request pending: found %0d x %0d y %0d count %0d",
                       m_found, m_found_x, m_found_y, m_point_count);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                if (m_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_found);
                    mismatch_count++;
                end
                if (m_found_x !== want.fx) begin
                    $error("found_x: expected %0d, got %0d", want.fx, m_found_x);
                    mismatch_count++;
                end
                if (m_found_y !== want.fy) begin
                    $error("found_y: expected %0d, got %0d", want.fy, m_found_y);
                    mismatch_count++;
                end
                if (m_point_count !== want.count) begin
                    $error("point_count: expected %0d, got %0d", want.count, m_point_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        grid_request_t req;
        grid_result_t  predicted;
        grid_result_t  typed_res;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_SIDE_DIST;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_cmd     <= CMD_ADD;
        s_x_coord <= '0;
        s_y_coord <= '0;
        s_heading <= '0;
        foreach (occupied[i]) occupied[i] = '0;
        marked    = '0;
        side_dist = SIDE_RESET;
        fwd_dist  = FWD_RESET;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests under the reset window
        foreach (directed_rows[i]) begin
            req.cmd     = directed_rows[i].cmd;
            req.x       = coord_t'(directed_rows[i].x);
            req.y       = coord_t'(directed_rows[i].y);
            req.heading = HEAD_W'(directed_rows[i].heading);
            send_request(req);
            predicted = apply_command(req);
            if (directed_rows[i].typed) begin
                typed_res.found = directed_rows[i].found;
                typed_res.fx    = coord_t'(directed_rows[i].fx);
                typed_res.fy    = coord_t'(directed_rows[i].fy);
                typed_res.count = COUNT_W'(directed_rows[i].count);
                awaited_results.push_back(typed_res);
            end else begin
                awaited_results.push_back(predicted);
            end
        end

        // Random phases, each with its own window and idle pattern
        foreach (phase_plans[p]) begin
            wait_for_results();
            if (phase_plans[p].rand_window) begin
                write_window($urandom_range(63), $urandom_range(63));
            end else begin
                write_window(phase_plans[p].side, phase_plans[p].fwd);
            end
            send_idle_pct  = phase_plans[p].send_idle;
            recv_stall_pct = phase_plans[p].recv_stall;
            hot_x = $urandom_range(63);
            hot_y = $urandom_range(63);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase_plans[p].pause_mid && n == PHASE_ITEMS / 2) begin
                    wait_for_results();
                end
                req = draw_request();
                send_request(req);
                awaited_results.push_back(apply_command(req));
            end
        end

        // Drain, then let the block settle before the verdict
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
design/gnp_pkg.sv
design/gnp_occ_mem.sv
design/gnp_col_eval.sv
design/grid_nearest_point_window_search.sv
design/gnp_checker.sv
verif/grid_nearest_point_window_search_test.sv
